>>> rtl/key_matrix_scan_event_assert.svh
// Assertion macros used by the key matrix scanner RTL.
`ifndef KEY_MATRIX_SCAN_EVENT_ASSERT_SVH
`define KEY_MATRIX_SCAN_EVENT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KMSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key matrix scanner check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define KMSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key matrix scanner check failed");

`endif

>>> rtl/kmse_pkg.sv
// Package with constants, types and the key event table of the key matrix scanner.
package kmse_pkg;

  localparam int unsigned ROWS_DEFAULT    = 3;
  localparam int unsigned COLUMNS_DEFAULT = 9;
  localparam int unsigned TABLE_ROWS      = 3;
  localparam int unsigned TABLE_COLS      = 9;
  localparam int unsigned SAMPLE_W        = 3;
  localparam int unsigned COL_W           = 4;
  localparam int unsigned INDEX_W         = 4;
  localparam logic        EMIT_LEVEL_RESET = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_NAV   = 2'd1,
    KIND_EDIT  = 2'd2,
    KIND_MEDIA = 2'd3
  } kind_e;

  // Column 0 holds the two navigation keys and the function key, the top row
  // holds the edit keys and the two lower rows hold the sixteen media keys.
  function automatic kind_e key_kind(int unsigned r, int unsigned c);
    kind_e k;
    k = KIND_NONE;
    if (r < TABLE_ROWS && c < TABLE_COLS) begin
      if (c == 0) begin
        k = (r == TABLE_ROWS - 1) ? KIND_NONE : KIND_NAV;
      end else if (r == 0) begin
        k = KIND_EDIT;
      end else begin
        k = KIND_MEDIA;
      end
    end
    return k;
  endfunction

  function automatic logic [INDEX_W-1:0] key_index(int unsigned r, int unsigned c);
    logic [INDEX_W-1:0] idx;
    idx = '0;
    if (r < TABLE_ROWS && c < TABLE_COLS) begin
      if (c == 0) begin
        idx = (r == TABLE_ROWS - 1) ? '0 : INDEX_W'(r);
      end else if (r == 0) begin
        idx = INDEX_W'(c - 1);
      end else begin
        idx = INDEX_W'((r - 1) * (TABLE_COLS - 1) + c - 1);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/key_matrix_scan_event.sv
// Key matrix scanner: stores one column of row levels per item and reports key events.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------------
//   sample  | in        | in_valid_i / in_stall_o   | row_sample_i
//   result  | out       | out_valid_o / out_stall_i | column_drive_o, scan_done_o, event_*_o,
//           |           |                           | function_key_o
//   config  | in        | cfg_valid_i / cfg_ready_o | emit_level_i
//
// One item per cycle while the result is not stalled: an input register feeds one pass of logic
// (key map update, lowest-set-bit pick over the changed keys, table select) into the result register.
// Every item gives exactly one result; event_valid_o is high only on the last column of a scan.
// Reset clears the column counter and both key maps and sets emit level to one.
// A stalled result holds the result register; the input register still takes one more item.

`include "key_matrix_scan_event_assert.svh"

module key_matrix_scan_event #(
  parameter int unsigned ROWS    = kmse_pkg::ROWS_DEFAULT,
  parameter int unsigned COLUMNS = kmse_pkg::COLUMNS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kmse_pkg::SAMPLE_W-1:0] row_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kmse_pkg::COL_W-1:0]   column_drive_o,
  output logic                         scan_done_o,
  output logic                         event_valid_o,
  output logic [1:0]                   event_kind_o,
  output logic [kmse_pkg::INDEX_W-1:0] event_index_o,
  output logic                         function_key_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         emit_level_i
);

  localparam int unsigned KEYS     = ROWS * COLUMNS;
  localparam int unsigned FUNC_BIT = (ROWS - 1) * COLUMNS;
  localparam int unsigned COL_W    = kmse_pkg::COL_W;
  localparam int unsigned IDX_W    = kmse_pkg::INDEX_W;

  // Input register
  logic                          in_valid_q, in_valid_d;
  logic [kmse_pkg::SAMPLE_W-1:0] sample_q;
  logic                          in_accept;
  logic                          take;
  logic                          advance;

  // Scan state
  logic [COL_W-1:0] col_q, col_d;
  logic [KEYS-1:0]  cur_q, cur_d;
  logic [KEYS-1:0]  prev_q, prev_d;
  logic             emit_level_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [COL_W-1:0]  column_drive_q;
  logic              scan_done_q;
  logic              event_valid_q;
  logic [1:0]        event_kind_q;
  logic [IDX_W-1:0]  event_index_q;
  logic              function_key_q;

  // Datapath
  logic [COL_W-1:0] col_eff;
  logic [COL_W-1:0] col_next;
  logic             last_col;
  logic [ROWS-1:0]  row_bits;
  logic [KEYS-1:0]  cur_new;
  logic [KEYS-1:0]  diff;
  logic [KEYS-1:0]  first_change;
  logic [1:0]       lut_kind [KEYS];
  logic [IDX_W-1:0] lut_index [KEYS];
  logic [1:0]       sel_kind;
  logic [IDX_W-1:0] sel_index;
  logic             found;
  logic             new_level;
  logic             emit;

  assign advance    = !out_valid_q || !out_stall_i;
  assign take       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign in_valid_d  = in_accept ? 1'b1 : (take ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  // A counter outside the column range is treated as column 0.
  assign col_eff  = ({1'b0, col_q} >= (COL_W + 1)'(COLUMNS)) ? '0 : col_q;
  assign last_col = (col_eff == COL_W'(COLUMNS - 1));
  assign col_next = last_col ? '0 : col_eff + COL_W'(1);

  // Sample bit 0 is the bottom row; rows beyond the sample width read as zero.
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    if (ROWS - 1 - r < kmse_pkg::SAMPLE_W) begin : g_in
      assign row_bits[r] = sample_q[ROWS - 1 - r];
    end else begin : g_zero
      assign row_bits[r] = 1'b0;
    end
  end

  // Key map is row-major: bit r*COLUMNS+c is row r, column c.
  always_comb begin
    cur_new = cur_q;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        if (COL_W'(c) == col_eff) begin
          cur_new[r * COLUMNS + c] = row_bits[r];
        end
      end
    end
  end

  // The first change in row-major order is the lowest set bit of the difference.
  assign diff         = cur_new ^ prev_q;
  assign first_change = diff & (~diff + KEYS'(1));
  assign found        = |diff;
  assign new_level    = |(first_change & cur_new);

  for (genvar i = 0; i < KEYS; i++) begin : g_lut
    assign lut_kind[i]  = kmse_pkg::key_kind(i / COLUMNS, i % COLUMNS);
    assign lut_index[i] = kmse_pkg::key_index(i / COLUMNS, i % COLUMNS);
  end

  always_comb begin
    sel_kind  = '0;
    sel_index = '0;
    for (int i = 0; i < KEYS; i++) begin
      sel_kind  = sel_kind  | (lut_kind[i]  & {2{first_change[i]}});
      sel_index = sel_index | (lut_index[i] & {IDX_W{first_change[i]}});
    end
  end

  assign emit = last_col && found && (sel_kind != kmse_pkg::KIND_NONE) &&
                (new_level == emit_level_q);

  assign col_d  = take ? col_next : col_q;
  assign cur_d  = take ? cur_new : cur_q;
  assign prev_d = (take && last_col) ? cur_new : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      col_q        <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      emit_level_q <= kmse_pkg::EMIT_LEVEL_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      if (cfg_valid_i) begin
        emit_level_q <= emit_level_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= row_sample_i;
    end
    if (take) begin
      column_drive_q <= col_next;
      scan_done_q    <= last_col;
      event_valid_q  <= emit;
      event_kind_q   <= emit ? sel_kind : '0;
      event_index_q  <= emit ? sel_index : '0;
      function_key_q <= cur_new[FUNC_BIT];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_drive_o = column_drive_q;
  assign scan_done_o    = scan_done_q;
  assign event_valid_o  = event_valid_q;
  assign event_kind_o   = event_kind_q;
  assign event_index_o  = event_index_q;
  assign function_key_o = function_key_q;

  `KMSE_ASSERT_NOW(a_col_in_range, 1'b1, {1'b0, col_q} < (COL_W + 1)'(COLUMNS))
  `KMSE_ASSERT_NOW(a_event_at_scan_end, out_valid_q && event_valid_q, scan_done_q)
  `KMSE_ASSERT_NEXT(a_prev_follows_scan, take && last_col, prev_q == cur_q)
  `KMSE_ASSERT_NEXT(a_col_steps, take && !last_col, col_q == $past(col_eff) + COL_W'(1))

endmodule
